// File: rtl/arct_pkg.sv
// shared types and constants of the angle rangefinder
package arct_pkg;

   localparam int ANGLE_W  = 17;
   localparam int HEIGHT_W = 23;
   localparam int DIST_W   = 40;
   localparam int OBJ_W    = 44;
   localparam int STATUS_W = 2;

   localparam logic [ANGLE_W-1:0]  ANGLE_MAX    = 17'd91750;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 23'd98304;
   localparam logic [DIST_W-1:0]   DIST_MAX     = '1;
   localparam logic [OBJ_W-1:0]    OBJ_MAX      = '1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ALPHA_ERR = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BETA_ERR  = 2'd2;

   typedef struct packed {
      logic                mode;
      logic [STATUS_W-1:0] status;
   } info_type;

endpackage

// File: rtl/angle_rangefinder_cfrac_tan.sv
// top level of the angle rangefinder: range check, tangents, distance and object height
//
// usage
//   a measurement word (req_mode, req_angle_alpha, req_angle_beta) is taken at a rising
//   edge with start high and busy low. busy is high during reset and is cleared by its register
//   once reset is released, then stays low, so a new word can be taken every cycle.
//   each word gives exactly one result word, shown for one cycle with rsp_valid high.
//   the receiver cannot stall; results leave in the order the words came in.
//   each pipelined divider retires one quotient bit per stage.
//   throughput: one word per cycle.
//   csr_wr_en/csr_wr_data write observer_height; the user must do so only while no word is
//   in flight, the block does not check it. reset empties the pipeline and sets observer_height to 1.5 m.
module angle_rangefinder_cfrac_tan import arct_pkg::*; #(
   parameter int ITERATIONS    = 8,
   parameter int FRACTION_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_mode,
   input  logic [ANGLE_W-1:0]  req_angle_alpha,
   input  logic [ANGLE_W-1:0]  req_angle_beta,
   input  logic                csr_wr_en,
   input  logic [HEIGHT_W-1:0] csr_wr_data,
   output logic                rsp_valid,
   output logic [DIST_W-1:0]   rsp_distance,
   output logic [OBJ_W-1:0]    rsp_object_height,
   output logic                rsp_height_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_saturated
);

   localparam int F    = FRACTION_BITS;
   localparam int XW   = F + 1;
   localparam int TW   = F + 3;
   localparam int DQ   = HEIGHT_W + F;
   localparam int DL   = (DQ + 1) / 2;
   localparam int DH   = DQ - DL;
   localparam int PW   = TW + DQ;
   localparam int PPW  = PW - F;
   localparam int IW   = $bits(info_type);
   localparam int DSW  = IW + 1 + TW;

   logic                busy_ff;
   logic [HEIGHT_W-1:0] height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b1;
         height_ff <= HEIGHT_RESET;
      end else begin
         busy_ff <= 1'b0;
         if (csr_wr_en) begin
            height_ff <= csr_wr_data;
         end
      end
   end

   assign busy = busy_ff;

   // stage a: range check
   logic                accept;
   logic                alpha_ok;
   logic                beta_ok;
   info_type            info_in;
   logic                vld_a_ff;
   info_type            info_a_ff;
   logic [ANGLE_W-1:0]  alpha_a_ff;
   logic [ANGLE_W-1:0]  beta_a_ff;

   assign accept   = start & ~busy_ff;
   assign alpha_ok = (req_angle_alpha != '0) && (req_angle_alpha <= ANGLE_MAX);
   assign beta_ok  = (req_angle_beta != '0) && (req_angle_beta <= ANGLE_MAX);

   always_comb begin
      info_in.mode = req_mode;
      if (!alpha_ok) begin
         info_in.status = STATUS_ALPHA_ERR;
      end else if (req_mode && !beta_ok) begin
         info_in.status = STATUS_BETA_ERR;
      end else begin
         info_in.status = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
      end else begin
         vld_a_ff <= accept;
      end
      info_a_ff  <= info_in;
      alpha_a_ff <= req_angle_alpha;
      beta_a_ff  <= req_angle_beta;
   end

   // stage b: x and x squared in Q.F
   logic          vld_b_ff;
   info_type      info_b_ff;
   logic [XW-1:0] xa_b_ff, xa2_b_ff, xb_b_ff, xb2_b_ff;
   logic [XW-1:0] xa_in, xa2_in, xb_in, xb2_in;
   logic [33:0]   sqa, sqb;

   assign sqa    = 34'(alpha_a_ff) * 34'(alpha_a_ff);
   assign sqb    = 34'(beta_a_ff) * 34'(beta_a_ff);
   assign xa_in  = XW'((33'(alpha_a_ff) << 16) >> (32 - F));
   assign xb_in  = XW'((33'(beta_a_ff) << 16) >> (32 - F));
   assign xa2_in = XW'(sqa >> (32 - F));
   assign xb2_in = XW'(sqb >> (32 - F));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_b_ff <= 1'b0;
      end else begin
         vld_b_ff <= vld_a_ff;
      end
      info_b_ff <= info_a_ff;
      xa_b_ff   <= xa_in;
      xa2_b_ff  <= xa2_in;
      xb_b_ff   <= xb_in;
      xb2_b_ff  <= xb2_in;
   end

   // tangents of both angles, same latency
   logic          vld_t;
   logic [TW-1:0] tan_a, tan_b;
   logic [IW-1:0] info_t;

   arct_cf_tan #(
      .ITERATIONS(ITERATIONS), .FRACTION_BITS(F), .SIDE_W(IW)
   ) u_tan_alpha (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (vld_b_ff),
      .x        (xa_b_ff),
      .x2       (xa2_b_ff),
      .side_in  (info_b_ff),
      .out_vld  (vld_t),
      .tan_val  (tan_a),
      .side_out (info_t)
   );

   arct_cf_tan #(
      .ITERATIONS(ITERATIONS), .FRACTION_BITS(F), .SIDE_W(1)
   ) u_tan_beta (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (vld_b_ff),
      .x        (xb_b_ff),
      .x2       (xb2_b_ff),
      .side_in  (1'b0),
      .out_vld  (),
      .tan_val  (tan_b),
      .side_out ()
   );

   // distance = height / tan(alpha), kept at full width
   logic           inf_t;
   logic           vld_d;
   logic [DQ-1:0]  dist_q;
   logic [DSW-1:0] side_d;

   assign inf_t = (tan_a == '0);

   arct_div #(
      .NUM_W(HEIGHT_W), .DEN_W(TW), .Q_W(DQ), .SHIFT(F), .SIDE_W(DSW)
   ) u_div_dist (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (vld_t),
      .num      (height_ff),
      .den      (tan_a),
      .side_in  ({info_t, inf_t, tan_b}),
      .out_vld  (vld_d),
      .quot     (dist_q),
      .side_out (side_d)
   );

   // stage m1: tan(beta) * distance as two partial products
   logic             vld_m1_ff;
   info_type         info_m1_ff;
   logic             inf_m1_ff;
   logic [DQ-1:0]    d_m1_ff;
   logic [TW+DL-1:0] pp_lo_m1_ff;
   logic [TW+DH-1:0] pp_hi_m1_ff;
   logic [TW-1:0]    tb_d;

   assign tb_d = side_d[TW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_m1_ff <= 1'b0;
      end else begin
         vld_m1_ff <= vld_d;
      end
      info_m1_ff  <= info_type'(side_d[DSW-1:TW+1]);
      inf_m1_ff   <= side_d[TW];
      d_m1_ff     <= dist_q;
      pp_lo_m1_ff <= (TW+DL)'(tb_d) * (TW+DL)'(dist_q[DL-1:0]);
      pp_hi_m1_ff <= (TW+DH)'(tb_d) * (TW+DH)'(dist_q[DQ-1:DL]);
   end

   // stage m2: combine and drop the fraction
   logic          vld_m2_ff;
   info_type      info_m2_ff;
   logic          inf_m2_ff;
   logic [DQ-1:0] d_m2_ff;
   logic [PPW-1:0] p_m2_ff;
   logic [PW-1:0] prod;

   assign prod = (PW'(pp_hi_m1_ff) << DL) + PW'(pp_lo_m1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_m2_ff <= 1'b0;
      end else begin
         vld_m2_ff <= vld_m1_ff;
      end
      info_m2_ff <= info_m1_ff;
      inf_m2_ff  <= inf_m1_ff;
      d_m2_ff    <= d_m1_ff;
      p_m2_ff    <= PPW'(prod >> F);
   end

   // output stage: add height, clip, apply status
   logic [PPW:0]        obj_sum;
   logic                dist_ovf;
   logic                obj_ovf;
   logic [DIST_W-1:0]   dist_in;
   logic [OBJ_W-1:0]    obj_in;
   logic                hv_in;
   logic                sat_in;

   logic                rsp_valid_ff;
   logic [DIST_W-1:0]   rsp_distance_ff;
   logic [OBJ_W-1:0]    rsp_object_height_ff;
   logic                rsp_height_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_saturated_ff;

   assign obj_sum  = (PPW+1)'(p_m2_ff) + (PPW+1)'(height_ff);
   assign dist_ovf = (d_m2_ff >> DIST_W) != '0;
   assign obj_ovf  = (obj_sum >> OBJ_W) != '0;

   always_comb begin
      dist_in = '0;
      obj_in  = '0;
      hv_in   = 1'b0;
      sat_in  = 1'b0;
      if (info_m2_ff.status == STATUS_OK) begin
         if (inf_m2_ff || dist_ovf) begin
            dist_in = DIST_MAX;
            sat_in  = 1'b1;
         end else begin
            dist_in = DIST_W'(d_m2_ff);
         end
         if (info_m2_ff.mode) begin
            hv_in = 1'b1;
            if (inf_m2_ff || obj_ovf) begin
               obj_in = OBJ_MAX;
               sat_in = 1'b1;
            end else begin
               obj_in = OBJ_W'(obj_sum);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld_m2_ff;
      end
      rsp_distance_ff      <= dist_in;
      rsp_object_height_ff <= obj_in;
      rsp_height_valid_ff  <= hv_in;
      rsp_status_ff        <= info_m2_ff.status;
      rsp_saturated_ff     <= sat_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_distance      = rsp_distance_ff;
   assign rsp_object_height = rsp_object_height_ff;
   assign rsp_height_valid  = rsp_height_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_saturated     = rsp_saturated_ff;

endmodule

// File: rtl/arct_div.sv
// pipelined restoring divider, one quotient bit per stage: floor(num * 2^SHIFT / den)
module arct_div import arct_pkg::*; #(
   parameter int NUM_W  = 17,
   parameter int DEN_W  = 17,
   parameter int Q_W    = 17,
   parameter int SHIFT  = 16,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_vld,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_vld,
   output logic [Q_W-1:0]    quot,
   output logic [SIDE_W-1:0] side_out
);

   localparam int NW = NUM_W + SHIFT;
   localparam int DW = DEN_W + Q_W;
   localparam int W  = (NW > DW) ? NW : DW;

   logic              vld_ff  [Q_W];
   logic [W-1:0]      rem_ff  [Q_W];
   logic [DEN_W-1:0]  den_ff  [Q_W];
   logic [Q_W-1:0]    quot_ff [Q_W];
   logic [SIDE_W-1:0] side_ff [Q_W];

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      localparam int J = Q_W - 1 - k;
      logic              vld_prev;
      logic [W-1:0]      rem_prev;
      logic [DEN_W-1:0]  den_prev;
      logic [Q_W-1:0]    quot_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [W:0]        diff;
      logic              take;
      logic [W-1:0]      rem_in;
      logic [Q_W-1:0]    quot_in;

      if (k == 0) begin : g_first
         assign vld_prev  = in_vld;
         assign rem_prev  = W'(num) << SHIFT;
         assign den_prev  = den;
         assign quot_prev = '0;
         assign side_prev = side_in;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign quot_prev = quot_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      // trial subtract of the divisor aligned to this quotient bit
      assign diff    = {1'b0, rem_prev} - ({1'b0, W'(den_prev)} << J);
      assign take    = ~diff[W];
      assign rem_in  = take ? diff[W-1:0] : rem_prev;
      assign quot_in = quot_prev | (Q_W'(take) << J);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_prev;
         end
         rem_ff[k]  <= rem_in;
         den_ff[k]  <= den_prev;
         quot_ff[k] <= quot_in;
         side_ff[k] <= side_prev;
      end
   end

   assign out_vld  = vld_ff[Q_W-1];
   assign quot     = quot_ff[Q_W-1];
   assign side_out = side_ff[Q_W-1];

endmodule

// File: rtl/arct_cf_tan.sv
// continued-fraction tangent, innermost term first, as a chain of pipelined dividers
module arct_cf_tan import arct_pkg::*; #(
   parameter int ITERATIONS    = 8,
   parameter int FRACTION_BITS = 16,
   parameter int SIDE_W        = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_vld,
   input  logic [FRACTION_BITS:0]   x,
   input  logic [FRACTION_BITS:0]   x2,
   input  logic [SIDE_W-1:0]        side_in,
   output logic                     out_vld,
   output logic [FRACTION_BITS+2:0] tan_val,
   output logic [SIDE_W-1:0]        side_out
);

   localparam int F  = FRACTION_BITS;
   localparam int XW = F + 1;
   localparam int CW = SIDE_W + 2 * XW;
   localparam int DW = F + 5;

   logic          vld_s [ITERATIONS];
   logic [XW-1:0] z_s   [ITERATIONS];
   logic [CW-1:0] ch_s  [ITERATIONS];

   assign vld_s[0] = in_vld;
   assign z_s[0]   = '0;
   assign ch_s[0]  = {side_in, x, x2};

   for (genvar s = 0; s < ITERATIONS - 1; s++) begin : g_term
      localparam int I = ITERATIONS - 1 - s;
      logic [DW-1:0] base;
      logic [DW-1:0] den;

      // z stays below 2 so the odd base never underflows
      assign base = DW'(2 * I + 1) << F;
      assign den  = base - DW'(z_s[s]);

      arct_div #(
         .NUM_W(XW), .DEN_W(DW), .Q_W(XW), .SHIFT(F), .SIDE_W(CW)
      ) u_div (
         .clock    (clock),
         .reset    (reset),
         .in_vld   (vld_s[s]),
         .num      (ch_s[s][XW-1:0]),
         .den      (den),
         .side_in  (ch_s[s]),
         .out_vld  (vld_s[s+1]),
         .quot     (z_s[s+1]),
         .side_out (ch_s[s+1])
      );
   end

   logic [XW-1:0] one;
   logic [XW-1:0] den_last;

   assign one      = XW'(1) << F;
   assign den_last = (z_s[ITERATIONS-1] < one) ? one - z_s[ITERATIONS-1] : '0;

   arct_div #(
      .NUM_W(XW), .DEN_W(XW), .Q_W(F + 3), .SHIFT(F), .SIDE_W(SIDE_W)
   ) u_div_last (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (vld_s[ITERATIONS-1]),
      .num      (ch_s[ITERATIONS-1][2*XW-1:XW]),
      .den      (den_last),
      .side_in  (ch_s[ITERATIONS-1][CW-1:2*XW]),
      .out_vld  (out_vld),
      .quot     (tan_val),
      .side_out (side_out)
   );

endmodule
